>>> rtl/core/egd_pkg.sv
`default_nettype none
package egd_pkg;

  localparam int NUM_FLOORS_DEF = 16;
  localparam int NUM_CARS_DEF   = 4;

  typedef enum logic [1:0] {
    REQ_DISPATCH = 2'd0,
    REQ_STEP     = 2'd1,
    REQ_LOAD     = 2'd2,
    REQ_NOP      = 2'd3
  } req_type_t;

  localparam logic [1:0] DIR_IDLE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  localparam int PEN_FULL      = 20;
  localparam int PEN_HIGH      = 5;
  localparam int PEN_WRONG_DIR = 10;
  localparam int BONUS_IDLE    = -5;
  localparam int ROOM_MARGIN   = 3;

  // scores carry an offset of -BONUS_IDLE so they stay unsigned
  localparam int SCORE_W      = 7;
  localparam int SCORE_IDLE   = 0;
  localparam int SCORE_TOWARD = 0 - BONUS_IDLE;
  localparam int SCORE_AWAY   = PEN_WRONG_DIR - BONUS_IDLE;

  localparam logic [5:0] CAP_RESET = 6'd8;

  typedef struct packed {
    logic load_req;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/egd_ctrl.sv
`default_nettype none
module egd_ctrl import egd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [1:0] in_tuser,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt = (req_type_t'(in_tuser) == REQ_DISPATCH) ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/egd_datapath.sv
`default_nettype none
module egd_datapath import egd_pkg::*; #(
  parameter int NUM_FLOORS = NUM_FLOORS_DEF,
  parameter int NUM_CARS   = NUM_CARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [1:0]  in_car,
  input  wire logic [3:0]  in_floor,
  input  wire logic [5:0]  in_load,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic [15:0]      out_data
);

  localparam int FW  = $clog2(NUM_FLOORS);
  localparam int CIW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam logic [FW-1:0]  TOP_FLOOR = FW'(NUM_FLOORS - 1);
  localparam logic [CIW-1:0] LAST_CAR  = CIW'(NUM_CARS - 1);

  function automatic logic [FW-1:0] lsb_index(input logic [NUM_FLOORS-1:0] x);
    logic [NUM_FLOORS-1:0] iso;
    logic [FW-1:0] idx;
    iso = x & (~x + 1'b1);
    idx = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (iso[i]) idx = idx | FW'(i);
    end
    return idx;
  endfunction

  function automatic logic [FW-1:0] msb_index(input logic [NUM_FLOORS-1:0] x);
    logic [NUM_FLOORS-1:0] rev;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      rev[i] = x[NUM_FLOORS-1-i];
    end
    return TOP_FLOOR - lsb_index(rev);
  endfunction

  logic [NUM_FLOORS-1:0] mask_r   [NUM_CARS];
  logic [FW-1:0]         pos_r    [NUM_CARS];
  logic [1:0]            head_r   [NUM_CARS];
  logic [5:0]            riders_r [NUM_CARS];
  logic [5:0]            cap_r;

  req_type_t       req_r;
  logic [1:0]      car_r;
  logic            car_ok_r;
  logic [FW-1:0]   floor_r;
  logic [5:0]      load_r;
  logic [CIW-1:0]  idx_r;
  logic [CIW-1:0]  best_r;
  logic [SCORE_W-1:0] best_score_r;

  logic [1:0] res_car_r;
  logic [3:0] res_floor_r;
  logic [1:0] res_dir_r;
  logic       res_stop_r;

  logic                  is_disp;
  logic [CIW-1:0]        tgt_idx, rd_idx;
  logic [NUM_FLOORS-1:0] rd_mask;
  logic [FW-1:0]         rd_pos;
  logic [1:0]            rd_head;
  logic [5:0]            rd_riders;

  assign is_disp   = (req_r == REQ_DISPATCH);
  assign tgt_idx   = is_disp ? best_r : CIW'(car_r);
  assign rd_idx    = cmd.scan ? idx_r : tgt_idx;
  assign rd_mask   = mask_r[rd_idx];
  assign rd_pos    = pos_r[rd_idx];
  assign rd_head   = head_r[rd_idx];
  assign rd_riders = riders_r[rd_idx];

  // scoring of the car under scan
  logic [5:0]         room;
  logic [SCORE_W-1:0] cap_term, dir_term, score;
  logic [FW-1:0]      fl_dist;
  logic               hit;

  always_comb begin
    room = cap_r - rd_riders;
    if (rd_riders >= cap_r) begin
      cap_term = SCORE_W'(PEN_FULL);
    end else if (room > 6'(ROOM_MARGIN)) begin
      cap_term = '0;
    end else begin
      cap_term = SCORE_W'(PEN_HIGH);
    end
    if (rd_head == DIR_IDLE) begin
      dir_term = SCORE_W'(SCORE_IDLE);
    end else if ((rd_head == DIR_UP && floor_r > rd_pos) ||
                 (rd_head == DIR_DOWN && floor_r < rd_pos)) begin
      dir_term = SCORE_W'(SCORE_TOWARD);
    end else begin
      dir_term = SCORE_W'(SCORE_AWAY);
    end
    fl_dist = (floor_r > rd_pos) ? floor_r - rd_pos : rd_pos - floor_r;
    score   = cap_term + dir_term + SCORE_W'(fl_dist);
    hit     = (rd_head == DIR_IDLE) && (rd_pos == floor_r);
  end

  assign sts.scan_done = hit || (idx_r == LAST_CAR);

  // LOOK search
  logic [NUM_FLOORS-1:0] ge_v, le_v, m_ge, m_le;
  logic [FW-1:0]         look_next;
  logic [1:0]            look_head;

  always_comb begin
    for (int i = 0; i < NUM_FLOORS; i++) begin
      ge_v[i] = (FW'(i) >= rd_pos);
      le_v[i] = (FW'(i) <= rd_pos);
    end
    m_ge = rd_mask & ge_v;
    m_le = rd_mask & le_v;
    case (rd_head)
      DIR_IDLE, DIR_UP: begin
        if (|m_ge) begin
          look_next = lsb_index(m_ge);
          look_head = DIR_UP;
        end else begin
          look_next = msb_index(rd_mask);
          look_head = DIR_DOWN;
        end
      end
      default: begin
        if (|m_le) begin
          look_next = msb_index(m_le);
          look_head = DIR_DOWN;
        end else begin
          look_next = lsb_index(rd_mask);
          look_head = DIR_UP;
        end
      end
    endcase
  end

  // commit values
  logic [NUM_FLOORS-1:0] floor_bit, next_bit;
  logic [NUM_FLOORS-1:0] new_mask;
  logic [FW-1:0]         new_pos;
  logic [1:0]            new_head;
  logic [5:0]            new_riders;
  logic                  new_stop;
  logic                  upd;

  always_comb begin
    floor_bit  = {{(NUM_FLOORS-1){1'b0}}, 1'b1} << floor_r;
    next_bit   = {{(NUM_FLOORS-1){1'b0}}, 1'b1} << look_next;
    new_mask   = rd_mask;
    new_pos    = rd_pos;
    new_head   = rd_head;
    new_riders = rd_riders;
    new_stop   = 1'b0;
    case (req_r)
      REQ_DISPATCH: begin
        new_mask = rd_mask | floor_bit;
        if (rd_head == DIR_IDLE) begin
          new_head = (floor_r > rd_pos) ? DIR_UP : DIR_DOWN;
        end
      end
      REQ_STEP: begin
        if (rd_mask == '0) begin
          new_head = DIR_IDLE;
          new_stop = 1'b1;
        end else begin
          new_mask = rd_mask & ~next_bit;
          new_pos  = look_next;
          new_head = look_head;
        end
      end
      REQ_LOAD: begin
        new_riders = (load_r > cap_r) ? cap_r : load_r;
      end
      default: begin
      end
    endcase
    upd = cmd.commit && (is_disp || car_ok_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      for (int c = 0; c < NUM_CARS; c++) begin
        mask_r[c]   <= '0;
        pos_r[c]    <= '0;
        head_r[c]   <= DIR_IDLE;
        riders_r[c] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (upd) begin
        mask_r[tgt_idx]   <= new_mask;
        pos_r[tgt_idx]    <= new_pos;
        head_r[tgt_idx]   <= new_head;
        riders_r[tgt_idx] <= new_riders;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r        <= req_type_t'(in_req_type);
      car_r        <= in_car;
      car_ok_r     <= (int'(in_car) < NUM_CARS);
      floor_r      <= (int'(in_floor) >= NUM_FLOORS) ? TOP_FLOOR : FW'(in_floor);
      load_r       <= in_load;
      idx_r        <= '0;
      best_r       <= '0;
      best_score_r <= '1;
    end
    if (cmd.scan) begin
      if (hit) begin
        best_r <= idx_r;
      end else if (score < best_score_r) begin
        best_score_r <= score;
        best_r       <= idx_r;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.commit) begin
      res_car_r <= is_disp ? 2'(best_r) : car_r;
      if (is_disp || car_ok_r) begin
        res_floor_r <= 4'(new_pos);
        res_dir_r   <= new_head;
        res_stop_r  <= new_stop;
      end else begin
        res_floor_r <= '0;
        res_dir_r   <= DIR_IDLE;
        res_stop_r  <= 1'b0;
      end
    end
  end

  assign out_data = {7'b0, res_stop_r, res_dir_r, res_floor_r, res_car_r};

endmodule
`default_nettype wire

>>> rtl/core/elevator_group_dispatch_look.sv
`default_nettype none
// Group dispatcher for NUM_CARS elevator cars over NUM_FLOORS floors. One
// beat in gives one beat out. Dispatch scores one car per cycle in the scan
// state, then commits and presents the result; the scan ends early when an
// idle car already stands at the floor. Step, load and no-op beats skip the
// scan. The block holds one beat at a time: in_tready is low from accept
// until the result beat is taken. car_capacity is to be written through
// cfg_wr_en/cfg_wr_data only while the block is idle; nothing enforces it.
module elevator_group_dispatch_look import egd_pkg::*; #(
  parameter int NUM_FLOORS = NUM_FLOORS_DEF,
  parameter int NUM_CARS   = NUM_CARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // car_index[1:0], floor[5:2], load[11:6]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // car_index_res[1:0], car_floor[5:2],
                                       // direction[7:6], stopped[8]
);

  cmd_t cmd;
  sts_t sts;

  egd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  egd_datapath #(
    .NUM_FLOORS (NUM_FLOORS),
    .NUM_CARS   (NUM_CARS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req_type (in_tuser),
    .in_car      (in_tdata[1:0]),
    .in_floor    (in_tdata[5:2]),
    .in_load     (in_tdata[11:6]),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/core/egd_checker.sv
`default_nettype none
module egd_checker import egd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while result pending");

  a_addr_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (req_type_t'(in_tuser) != REQ_DISPATCH) |=> ##1
      out_tvalid && (out_tdata[1:0] == $past(in_tdata[1:0], 2)))
    else $error("non-dispatch result wrong car or late");

  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7:6] == DIR_IDLE)
    else $error("stopped car not idle");

endmodule

bind elevator_group_dispatch_look egd_checker u_egd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
